// ----- rtl/kalman_filter_predict_update_top_macros.svh -----
// Assertion macros for the Kalman filter block.
// Used by kalman_filter_predict_update_top; expects clk_i and rst_ni in scope.
`ifndef KALMAN_FILTER_PREDICT_UPDATE_TOP_MACROS_SVH
`define KALMAN_FILTER_PREDICT_UPDATE_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define KFPU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KFPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kfpu_pkg.sv -----
// Package for the Kalman filter block: sizes, memory map, codes, microprogram
// and fixed-point helper functions. No dependencies.
`default_nettype none

package kfpu_pkg;

  localparam int unsigned SS    = 4;   // state size
  localparam int unsigned MS    = 2;   // measurement size
  localparam int unsigned W     = 32;  // word bits
  localparam int unsigned F     = 16;  // fraction bits
  localparam int unsigned ACC_W = W + 4;
  localparam int unsigned AW    = 7;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned STORED = 64;  // words that reset clears
  localparam int unsigned CLR_W = 6;
  localparam int unsigned DIM_W = 3;
  localparam int unsigned IDX_W = 2;
  localparam int unsigned PC_W  = 5;
  localparam int unsigned Q_W   = 2 * W + 1 - F;  // rounded product width
  localparam int unsigned NUM_W = W + F + 1;      // divider numerator width
  localparam int unsigned FIN_W = (Q_W > NUM_W) ? Q_W : NUM_W;
  localparam int unsigned DCNT_W = 6;

  // Word memory map: stored matrices first, scratch after.
  localparam logic [AW-1:0] X_BASE   = AW'(0);
  localparam logic [AW-1:0] P_BASE   = AW'(4);
  localparam logic [AW-1:0] F_BASE   = AW'(20);
  localparam logic [AW-1:0] H_BASE   = AW'(36);
  localparam logic [AW-1:0] R_BASE   = AW'(44);
  localparam logic [AW-1:0] Q_BASE   = AW'(48);
  localparam logic [AW-1:0] T_BASE   = AW'(64);
  localparam logic [AW-1:0] Y_BASE   = AW'(80);
  localparam logic [AW-1:0] PH_BASE  = AW'(82);
  localparam logic [AW-1:0] S_BASE   = AW'(90);
  localparam logic [AW-1:0] COF_BASE = AW'(94);
  localparam logic [AW-1:0] DET_BASE = AW'(98);
  localparam logic [AW-1:0] SI_BASE  = AW'(99);
  localparam logic [AW-1:0] K_BASE   = AW'(103);
  localparam logic [AW-1:0] KH_BASE  = AW'(111);

  localparam logic [2:0] SEL_STATE  = 3'd0;
  localparam logic [2:0] SEL_COV    = 3'd1;
  localparam logic [2:0] SEL_TRANS  = 3'd2;
  localparam logic [2:0] SEL_HMAP   = 3'd3;
  localparam logic [2:0] SEL_RNOISE = 3'd4;
  localparam logic [2:0] SEL_QNOISE = 3'd5;

  localparam logic [PC_W-1:0] PRED_PC = PC_W'(0);
  localparam logic [PC_W-1:0] UPD_PC  = PC_W'(5);

  localparam logic signed [ACC_W-1:0] ONE_ACC =
    {{(ACC_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [2*W:0] RND_HALF = (2*W+1)'(1) << (F - 1);

  typedef enum logic [1:0] {ACT_LOAD, ACT_PREDICT, ACT_UPDATE, ACT_READ} action_e;
  typedef enum logic [1:0] {STAT_OK, STAT_SINGULAR, STAT_SAT, STAT_BAD} status_e;

  typedef enum logic [2:0] {
    OP_MUL, OP_COPY, OP_SUBY, OP_COF, OP_CHKDET, OP_DIV, OP_IMK, OP_END
  } op_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RDWAIT, S_OP, S_MADD, S_MADD2, S_MRD,
    S_MMUL, S_MACC, S_MWR, S_ERD, S_EWR, S_DIV, S_DIVWR, S_DONE
  } state_e;

  typedef struct packed {
    op_e              kind;
    logic [AW-1:0]    dst;
    logic [AW-1:0]    a;
    logic [AW-1:0]    b;
    logic [AW-1:0]    c;
    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] k;
    logic [DIM_W-1:0] m;
    logic             bt;
    logic             add;
  } op_t;

  typedef struct packed {
    logic                sat;
    logic signed [W-1:0] word;
  } sword_t;

  typedef struct packed {
    logic          ok;
    logic [AW-1:0] addr;
  } loc_t;

  function automatic op_t mk(op_e kind, logic [AW-1:0] dst, logic [AW-1:0] a,
                             logic [AW-1:0] b, logic [AW-1:0] c, int unsigned n,
                             int unsigned k, int unsigned m, logic bt, logic add);
    op_t o;
    o.kind = kind;
    o.dst  = dst;
    o.a    = a;
    o.b    = b;
    o.c    = c;
    o.n    = DIM_W'(n);
    o.k    = DIM_W'(k);
    o.m    = DIM_W'(m);
    o.bt   = bt;
    o.add  = add;
    return o;
  endfunction

  // Predict runs from PRED_PC, update from UPD_PC; each ends in OP_END.
  function automatic op_t prog(logic [PC_W-1:0] pc);
    op_t o;
    case (pc)
      5'd0:  o = mk(OP_MUL, T_BASE, F_BASE, X_BASE, X_BASE, SS, SS, 1, 1'b0, 1'b0);
      5'd1:  o = mk(OP_COPY, X_BASE, T_BASE, X_BASE, X_BASE, SS, 1, 1, 1'b0, 1'b0);
      5'd2:  o = mk(OP_MUL, T_BASE, F_BASE, P_BASE, X_BASE, SS, SS, SS, 1'b0, 1'b0);
      5'd3:  o = mk(OP_MUL, P_BASE, T_BASE, F_BASE, Q_BASE, SS, SS, SS, 1'b1, 1'b1);
      5'd4:  o = mk(OP_END, X_BASE, X_BASE, X_BASE, X_BASE, 1, 1, 1, 1'b0, 1'b0);
      5'd5:  o = mk(OP_MUL, Y_BASE, H_BASE, X_BASE, X_BASE, MS, SS, 1, 1'b0, 1'b0);
      5'd6:  o = mk(OP_SUBY, Y_BASE, Y_BASE, X_BASE, X_BASE, MS, 1, 1, 1'b0, 1'b0);
      5'd7:  o = mk(OP_MUL, PH_BASE, P_BASE, H_BASE, X_BASE, SS, SS, MS, 1'b1, 1'b0);
      5'd8:  o = mk(OP_MUL, S_BASE, H_BASE, PH_BASE, R_BASE, MS, SS, MS, 1'b0, 1'b1);
      5'd9:  o = mk(OP_COF, COF_BASE, S_BASE, X_BASE, X_BASE, MS, 1, MS, 1'b0, 1'b0);
      5'd10: o = mk(OP_MUL, DET_BASE, S_BASE, COF_BASE, X_BASE, 1, MS, 1, 1'b0, 1'b0);
      5'd11: o = mk(OP_CHKDET, DET_BASE, DET_BASE, X_BASE, X_BASE, 1, 1, 1, 1'b0, 1'b0);
      5'd12: o = mk(OP_DIV, SI_BASE, COF_BASE, X_BASE, X_BASE, MS, 1, MS, 1'b0, 1'b0);
      5'd13: o = mk(OP_MUL, K_BASE, PH_BASE, SI_BASE, X_BASE, SS, MS, MS, 1'b0, 1'b0);
      5'd14: o = mk(OP_MUL, X_BASE, K_BASE, Y_BASE, X_BASE, SS, MS, 1, 1'b0, 1'b1);
      5'd15: o = mk(OP_MUL, KH_BASE, K_BASE, H_BASE, X_BASE, SS, MS, SS, 1'b0, 1'b0);
      5'd16: o = mk(OP_IMK, KH_BASE, KH_BASE, X_BASE, X_BASE, SS, 1, SS, 1'b0, 1'b0);
      5'd17: o = mk(OP_MUL, T_BASE, KH_BASE, P_BASE, X_BASE, SS, SS, SS, 1'b0, 1'b0);
      5'd18: o = mk(OP_COPY, P_BASE, T_BASE, X_BASE, X_BASE, SS, 1, SS, 1'b0, 1'b0);
      default: o = mk(OP_END, X_BASE, X_BASE, X_BASE, X_BASE, 1, 1, 1, 1'b0, 1'b0);
    endcase
    return o;
  endfunction

  function automatic loc_t locate(logic [2:0] sel, logic [1:0] row, logic [1:0] col);
    loc_t l;
    logic [AW-1:0] r;
    logic [AW-1:0] c;
    r = AW'(row);
    c = AW'(col);
    l.ok   = 1'b0;
    l.addr = X_BASE;
    case (sel)
      SEL_STATE: begin
        l.ok   = r < AW'(SS);
        l.addr = X_BASE + r;
      end
      SEL_COV: begin
        l.ok   = (r < AW'(SS)) && (c < AW'(SS));
        l.addr = P_BASE + r * AW'(SS) + c;
      end
      SEL_TRANS: begin
        l.ok   = (r < AW'(SS)) && (c < AW'(SS));
        l.addr = F_BASE + r * AW'(SS) + c;
      end
      SEL_HMAP: begin
        l.ok   = (r < AW'(MS)) && (c < AW'(SS));
        l.addr = H_BASE + r * AW'(SS) + c;
      end
      SEL_RNOISE: begin
        l.ok   = (r < AW'(MS)) && (c < AW'(MS));
        l.addr = R_BASE + r * AW'(MS) + c;
      end
      SEL_QNOISE: begin
        l.ok   = (r < AW'(SS)) && (c < AW'(SS));
        l.addr = Q_BASE + r * AW'(SS) + c;
      end
      default: l.ok = 1'b0;
    endcase
    return l;
  endfunction

  function automatic logic [W-1:0] mag(logic signed [W-1:0] a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

  function automatic sword_t clamp_acc(logic signed [ACC_W-1:0] v);
    sword_t s;
    logic signed [ACC_W-1:0] wmax;
    logic signed [ACC_W-1:0] wmin;
    wmax = {{(ACC_W-W+1){1'b0}}, {(W-1){1'b1}}};
    wmin = {{(ACC_W-W+1){1'b1}}, {(W-1){1'b0}}};
    s.sat  = 1'b0;
    s.word = v[W-1:0];
    if (v > wmax) begin
      s.sat  = 1'b1;
      s.word = wmax[W-1:0];
    end else if (v < wmin) begin
      s.sat  = 1'b1;
      s.word = wmin[W-1:0];
    end
    return s;
  endfunction

  // Clamp a magnitude to the word range for the given sign and apply the sign.
  function automatic sword_t finish(logic [FIN_W-1:0] q, logic neg);
    sword_t s;
    logic [FIN_W-1:0] lim;
    logic [FIN_W-1:0] mq;
    lim = FIN_W'({1'b0, {(W-1){1'b1}}}) + FIN_W'(neg);
    mq  = q;
    s.sat = 1'b0;
    if (q > lim) begin
      s.sat = 1'b1;
      mq    = lim;
    end
    s.word = neg ? -signed'(mq[W-1:0]) : signed'(mq[W-1:0]);
    return s;
  endfunction

  // Round a product magnitude to nearest, ties away from zero, then clamp.
  function automatic sword_t rnd_clamp(logic [2*W-1:0] prod, logic neg);
    logic [2*W:0] r;
    r = (2*W+1)'(prod) + RND_HALF;
    return finish(FIN_W'(r[2*W:F]), neg);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kalman_filter_predict_update_top.sv -----
// Kalman filter with 4 states and 2 measurements in signed Q15.16.
// Uses kfpu_pkg and kalman_filter_predict_update_top_macros.svh.
//
// Input channel (in_valid_i/in_ready_o) carries one item: load, predict,
// update or read. Output channel (out_valid_o/out_ready_i) returns one
// result per item: read_value_o (zero except for reads) and status_o.
// All matrices live in one 128-word register memory with two registered
// read ports; one multiplier, one accumulator and a bit-serial divider are
// shared under a microprogram sequencer, so only one item is in work.
// An update item stops early when the innovation covariance is singular.
// The run time of predict and update is set by the multiply, round and
// accumulate step per product (read, multiply and accumulate states) and
// the 49-step divider for the gain. in_ready_o rises together
// with out_valid_o, so without stalls the next item can be accepted as soon
// as a result is presented. After reset a clearing pass zeroes the 64 words
// of stored matrices; in_ready_o stays low during it. A finished result sits in an
// output register; a new item may be accepted while it waits, and if the
// receiver stalls the block holds the next result internally until the
// output register frees up.
`default_nettype none

`include "kalman_filter_predict_update_top_macros.svh"

module kalman_filter_predict_update_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [2:0]         matrix_select_i,
  input  wire logic [1:0]         row_i,
  input  wire logic [1:0]         col_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic signed [31:0] meas_0_i,
  input  wire logic signed [31:0] meas_1_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      read_value_o,
  output logic [1:0]              status_o
);

  localparam int unsigned W     = kfpu_pkg::W;
  localparam int unsigned AW    = kfpu_pkg::AW;
  localparam int unsigned ACC_W = kfpu_pkg::ACC_W;
  localparam int unsigned NUM_W = kfpu_pkg::NUM_W;
  localparam int unsigned IDX_W = kfpu_pkg::IDX_W;
  localparam int unsigned DIM_W = kfpu_pkg::DIM_W;

  kfpu_pkg::state_e state_q, state_d;
  kfpu_pkg::action_e act_q, act_d;
  kfpu_pkg::status_e res_st_q, res_st_d, out_st_q, out_st_d;

  logic [kfpu_pkg::CLR_W-1:0]  clr_q, clr_d;
  logic [AW-1:0]               addr_q, addr_d;
  logic                        loc_ok_q, loc_ok_d;
  logic signed [W-1:0]         value_q, value_d, meas0_q, meas0_d, meas1_q, meas1_d;
  logic [kfpu_pkg::PC_W-1:0]   pc_q, pc_d;
  logic [IDX_W-1:0]            i_q, i_d, j_q, j_d, p_q, p_d;
  logic signed [ACC_W-1:0]     acc_q, acc_d;
  logic [2*W-1:0]              prod_q, prod_d;
  logic                        pneg_q, pneg_d, sat_q, sat_d;
  logic [W-1:0]                dsr_q, dsr_d;
  logic                        dneg_q, dneg_d, qneg_q, qneg_d;
  logic [NUM_W-1:0]            num_q, num_d;
  logic [W:0]                  rem_q, rem_d;
  logic [kfpu_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;
  logic signed [W-1:0]         res_val_q, res_val_d, out_val_q, out_val_d;
  logic                        out_valid_q, out_valid_d;

  logic signed [W-1:0] mem [kfpu_pkg::DEPTH];
  logic signed [W-1:0] rdata_a_q, rdata_b_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, rd_a, rd_b;
  logic signed [W-1:0] mem_wdata;

  kfpu_pkg::op_t    op;
  kfpu_pkg::loc_t   loc;
  kfpu_pkg::sword_t sw;
  logic [AW-1:0]    e_off, a_off, b_off, src_off;
  logic             last_i, last_j, last_p, elem_last;
  logic [IDX_W-1:0] next_i, next_j;
  logic signed [ACC_W-1:0] rd_ext;
  logic [W+1:0]     rem_sh;
  logic [W+1:0]     dd;
  logic             qbit;
  logic             accept, out_load;

  assign op     = kfpu_pkg::prog(pc_q);
  assign loc    = kfpu_pkg::locate(matrix_select_i, row_i, col_i);
  assign rd_ext = ACC_W'(rdata_a_q);

  assign e_off = AW'(i_q) * AW'(op.m) + AW'(j_q);
  assign a_off = AW'(i_q) * AW'(op.k) + AW'(p_q);
  assign b_off = op.bt ? AW'(j_q) * AW'(op.k) + AW'(p_q)
                       : AW'(p_q) * AW'(op.m) + AW'(j_q);

  always_comb begin
    case (op.kind)
      kfpu_pkg::OP_COF: src_off = AW'(op.n) * AW'(op.m) - AW'(1) - e_off;
      kfpu_pkg::OP_DIV: src_off = AW'(j_q) * AW'(op.n) + AW'(i_q);
      default:          src_off = e_off;
    endcase
  end

  assign last_i    = ({1'b0, i_q} == op.n - DIM_W'(1));
  assign last_j    = ({1'b0, j_q} == op.m - DIM_W'(1));
  assign last_p    = ({1'b0, p_q} == op.k - DIM_W'(1));
  assign elem_last = last_i && last_j;
  assign next_j    = last_j ? '0 : j_q + IDX_W'(1);
  assign next_i    = last_j ? i_q + IDX_W'(1) : i_q;

  // Restoring divider step: one quotient bit per cycle.
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign dd     = {1'b0, dsr_q, 1'b0};
  assign qbit   = (rem_sh >= dd);

  assign in_ready_o = (state_q == kfpu_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == kfpu_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    res_st_d    = res_st_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    loc_ok_d    = loc_ok_q;
    value_d     = value_q;
    meas0_d     = meas0_q;
    meas1_d     = meas1_q;
    pc_d        = pc_q;
    i_d         = i_q;
    j_d         = j_q;
    p_d         = p_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    pneg_d      = pneg_q;
    sat_d       = sat_q;
    dsr_d       = dsr_q;
    dneg_d      = dneg_q;
    qneg_d      = qneg_q;
    num_d       = num_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    res_val_d   = res_val_q;
    sw          = kfpu_pkg::clamp_acc(acc_q);
    mem_we      = 1'b0;
    mem_waddr   = op.dst + e_off;
    mem_wdata   = sw.word;
    rd_a        = op.a + src_off;
    rd_b        = op.b + b_off;

    case (state_q)
      kfpu_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(clr_q);
        mem_wdata = '0;
        clr_d     = clr_q + kfpu_pkg::CLR_W'(1);
        if (clr_q == kfpu_pkg::CLR_W'(kfpu_pkg::STORED - 1)) begin
          state_d = kfpu_pkg::S_IDLE;
        end
      end
      kfpu_pkg::S_IDLE: begin
        if (accept) begin
          act_d    = kfpu_pkg::action_e'(action_i);
          addr_d   = loc.addr;
          loc_ok_d = loc.ok;
          value_d  = value_i;
          meas0_d  = meas_0_i;
          meas1_d  = meas_1_i;
          sat_d    = 1'b0;
          state_d  = kfpu_pkg::S_DECODE;
        end
      end
      kfpu_pkg::S_DECODE: begin
        rd_a      = addr_q;
        res_val_d = '0;
        case (act_q)
          kfpu_pkg::ACT_PREDICT: begin
            pc_d    = kfpu_pkg::PRED_PC;
            state_d = kfpu_pkg::S_OP;
          end
          kfpu_pkg::ACT_UPDATE: begin
            pc_d    = kfpu_pkg::UPD_PC;
            state_d = kfpu_pkg::S_OP;
          end
          kfpu_pkg::ACT_LOAD: begin
            res_st_d = loc_ok_q ? kfpu_pkg::STAT_OK : kfpu_pkg::STAT_BAD;
            mem_we    = loc_ok_q;
            mem_waddr = addr_q;
            mem_wdata = value_q;
            state_d   = kfpu_pkg::S_DONE;
          end
          default: begin
            res_st_d = loc_ok_q ? kfpu_pkg::STAT_OK : kfpu_pkg::STAT_BAD;
            state_d  = loc_ok_q ? kfpu_pkg::S_RDWAIT : kfpu_pkg::S_DONE;
          end
        endcase
      end
      kfpu_pkg::S_RDWAIT: begin
        res_val_d = rdata_a_q;
        state_d   = kfpu_pkg::S_DONE;
      end
      kfpu_pkg::S_OP: begin
        i_d   = '0;
        j_d   = '0;
        p_d   = '0;
        acc_d = '0;
        case (op.kind)
          kfpu_pkg::OP_END: begin
            res_st_d  = sat_q ? kfpu_pkg::STAT_SAT : kfpu_pkg::STAT_OK;
            res_val_d = '0;
            state_d   = kfpu_pkg::S_DONE;
          end
          kfpu_pkg::OP_MUL: state_d = op.add ? kfpu_pkg::S_MADD : kfpu_pkg::S_MRD;
          default:          state_d = kfpu_pkg::S_ERD;
        endcase
      end
      kfpu_pkg::S_MADD: begin
        rd_a    = op.c + e_off;
        state_d = kfpu_pkg::S_MADD2;
      end
      kfpu_pkg::S_MADD2: begin
        acc_d   = rd_ext;
        state_d = kfpu_pkg::S_MRD;
      end
      kfpu_pkg::S_MRD: begin
        rd_a    = op.a + a_off;
        rd_b    = op.b + b_off;
        state_d = kfpu_pkg::S_MMUL;
      end
      kfpu_pkg::S_MMUL: begin
        prod_d  = (2*W)'(kfpu_pkg::mag(rdata_a_q)) * (2*W)'(kfpu_pkg::mag(rdata_b_q));
        pneg_d  = rdata_a_q[W-1] ^ rdata_b_q[W-1];
        state_d = kfpu_pkg::S_MACC;
      end
      kfpu_pkg::S_MACC: begin
        sw    = kfpu_pkg::rnd_clamp(prod_q, pneg_q);
        acc_d = acc_q + ACC_W'(sw.word);
        sat_d = sat_q | sw.sat;
        if (last_p) begin
          state_d = kfpu_pkg::S_MWR;
        end else begin
          p_d     = p_q + IDX_W'(1);
          state_d = kfpu_pkg::S_MRD;
        end
      end
      kfpu_pkg::S_MWR: begin
        mem_we = 1'b1;
        sat_d  = sat_q | sw.sat;
        p_d    = '0;
        acc_d  = '0;
        i_d    = next_i;
        j_d    = next_j;
        if (elem_last) begin
          pc_d    = pc_q + kfpu_pkg::PC_W'(1);
          state_d = kfpu_pkg::S_OP;
        end else begin
          state_d = op.add ? kfpu_pkg::S_MADD : kfpu_pkg::S_MRD;
        end
      end
      kfpu_pkg::S_ERD: begin
        state_d = kfpu_pkg::S_EWR;
      end
      kfpu_pkg::S_EWR: begin
        case (op.kind)
          kfpu_pkg::OP_COPY: sw = '{sat: 1'b0, word: rdata_a_q};
          kfpu_pkg::OP_SUBY:
            sw = kfpu_pkg::clamp_acc(ACC_W'((i_q == '0) ? meas0_q : meas1_q) - rd_ext);
          kfpu_pkg::OP_COF: begin
            if (i_q != j_q) begin
              sw = kfpu_pkg::clamp_acc(-rd_ext);
            end else begin
              sw = '{sat: 1'b0, word: rdata_a_q};
            end
          end
          kfpu_pkg::OP_IMK:
            sw = kfpu_pkg::clamp_acc(((i_q == j_q) ? kfpu_pkg::ONE_ACC : '0) - rd_ext);
          default: sw = '{sat: 1'b0, word: rdata_a_q};
        endcase
        mem_wdata = sw.word;
        case (op.kind)
          kfpu_pkg::OP_CHKDET: begin
            if (rdata_a_q == '0) begin
              res_st_d  = kfpu_pkg::STAT_SINGULAR;
              res_val_d = '0;
              state_d   = kfpu_pkg::S_DONE;
            end else begin
              dsr_d   = kfpu_pkg::mag(rdata_a_q);
              dneg_d  = rdata_a_q[W-1];
              pc_d    = pc_q + kfpu_pkg::PC_W'(1);
              state_d = kfpu_pkg::S_OP;
            end
          end
          kfpu_pkg::OP_DIV: begin
            // Numerator is |a| * 2^(F+1) + |d|, divided by 2|d|, for rounding.
            num_d   = (NUM_W'(kfpu_pkg::mag(rdata_a_q)) << (kfpu_pkg::F + 1))
                      + NUM_W'(dsr_q);
            rem_d   = '0;
            dcnt_d  = '0;
            qneg_d  = rdata_a_q[W-1] ^ dneg_q;
            state_d = kfpu_pkg::S_DIV;
          end
          kfpu_pkg::OP_COPY, kfpu_pkg::OP_SUBY, kfpu_pkg::OP_COF,
          kfpu_pkg::OP_IMK: begin
            mem_we = 1'b1;
            sat_d  = sat_q | sw.sat;
            i_d    = next_i;
            j_d    = next_j;
            if (elem_last) begin
              pc_d    = pc_q + kfpu_pkg::PC_W'(1);
              state_d = kfpu_pkg::S_OP;
            end else begin
              state_d = kfpu_pkg::S_ERD;
            end
          end
          default: state_d = kfpu_pkg::S_OP;
        endcase
      end
      kfpu_pkg::S_DIV: begin
        rem_d  = qbit ? (W+1)'(rem_sh - dd) : rem_sh[W:0];
        num_d  = {num_q[NUM_W-2:0], qbit};
        dcnt_d = dcnt_q + kfpu_pkg::DCNT_W'(1);
        if (dcnt_q == kfpu_pkg::DCNT_W'(NUM_W - 1)) begin
          state_d = kfpu_pkg::S_DIVWR;
        end
      end
      kfpu_pkg::S_DIVWR: begin
        sw        = kfpu_pkg::finish(kfpu_pkg::FIN_W'(num_q), qneg_q);
        mem_wdata = sw.word;
        mem_we    = 1'b1;
        sat_d     = sat_q | sw.sat;
        i_d       = next_i;
        j_d       = next_j;
        if (elem_last) begin
          pc_d    = pc_q + kfpu_pkg::PC_W'(1);
          state_d = kfpu_pkg::S_OP;
        end else begin
          state_d = kfpu_pkg::S_ERD;
        end
      end
      kfpu_pkg::S_DONE: begin
        if (out_load) begin
          state_d = kfpu_pkg::S_IDLE;
        end
      end
      default: state_d = kfpu_pkg::S_IDLE;
    endcase
  end

  // Output register: holds a result until its transfer completes.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_val_d   = res_val_q;
      out_st_d    = res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kfpu_pkg::S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      sat_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      sat_q       <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    res_st_q  <= res_st_d;
    out_st_q  <= out_st_d;
    addr_q    <= addr_d;
    loc_ok_q  <= loc_ok_d;
    value_q   <= value_d;
    meas0_q   <= meas0_d;
    meas1_q   <= meas1_d;
    pc_q      <= pc_d;
    i_q       <= i_d;
    j_q       <= j_d;
    p_q       <= p_d;
    acc_q     <= acc_d;
    prod_q    <= prod_d;
    pneg_q    <= pneg_d;
    dsr_q     <= dsr_d;
    dneg_q    <= dneg_d;
    qneg_q    <= qneg_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    dcnt_q    <= dcnt_d;
    res_val_q <= res_val_d;
    out_val_q <= out_val_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_a_q <= mem[rd_a];
    rdata_b_q <= mem[rd_b];
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_val_q;
  assign status_o     = out_st_q;

  `KFPU_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o, "ready stayed high after a transfer")
  `KFPU_ASSERT_SAME(a_result_from_done, $rose(out_valid_o), $past(state_q == kfpu_pkg::S_DONE), "result appeared outside the done state")
  `KFPU_ASSERT_SAME(a_div_bound, state_q == kfpu_pkg::S_DIV, dcnt_q < kfpu_pkg::DCNT_W'(NUM_W), "divider ran past its step count")

endmodule

`default_nettype wire
